>>> rtl/core/assert_macros.svh
// Assertion macros shared by the RTL of the fingerprint to bucket block.
// Each macro expects a clock named clk and a synchronous reset named rst in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> rtl/core/fbd_pkg.sv
// Shared widths, codes, reset values and structs of the fingerprint to bucket block.
// No dependencies; every RTL module refers to it by scoped names.
package fbd_pkg;

  localparam int FP_W           = 64;
  localparam int IDX_W          = 32;
  localparam int RATE_W         = 48;
  localparam int VAL_W          = 33;
  localparam int SIZE_W         = 33;
  localparam int FRAC_W         = 48;
  localparam int K_W            = 4;
  localparam int L_W            = 36;
  localparam int TZ_W           = 7;
  localparam int CFG_IDX_W      = 3;
  localparam int LOG_ITERATIONS = 32;

  // Pipeline depths: the remainder takes one bit of the fingerprint per stage.
  localparam int MOD_LAT = FP_W;
  localparam int EXP_LAT = 9 + LOG_ITERATIONS;
  localparam int EXP_PAD = MOD_LAT - EXP_LAT;

  localparam logic [RATE_W-1:0] ONE_Q32 = 48'h0001_0000_0000;
  localparam logic [31:0]       LN2_Q32 = 32'hB172_17F8;

  localparam logic [1:0]        MODE_RESET      = 2'd0;
  localparam logic [IDX_W-1:0]  MIN_RESET       = 32'd0;
  localparam logic [IDX_W-1:0]  MAX_RESET       = 32'd1023;
  localparam logic [RATE_W-1:0] EXP_RATE_RESET  = 48'd11674931554;
  localparam logic [RATE_W-1:0] INV_RATE_RESET  = 48'd4294967296;

  typedef enum logic [1:0] {
    MODE_UNIFORM     = 2'd0,
    MODE_GEOMETRIC   = 2'd1,
    MODE_EXPONENTIAL = 2'd2
  } mode_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_MODE         = 3'd0,
    CFG_MIN_INDEX    = 3'd1,
    CFG_MAX_INDEX    = 3'd2,
    CFG_EXP_OF_RATE  = 3'd3,
    CFG_INVERSE_RATE = 3'd4
  } cfg_index_t;

  typedef enum logic [1:0] {
    STATUS_IN_RANGE = 2'd0,
    STATUS_BELOW    = 2'd1,
    STATUS_ABOVE    = 2'd2
  } status_t;

  typedef struct packed {
    logic [RATE_W-1:0] exp_rate;
    logic [RATE_W-1:0] exp_minus_one;
    logic [RATE_W-1:0] inv_rate;
    logic [SIZE_W-1:0] size;
  } exp_cfg_t;

  typedef struct packed {
    logic [VAL_W-1:0] val;
    logic             neg;
  } exp_res_t;

endpackage

>>> rtl/core/fingerprint_to_bucket_distribution.sv
// Fingerprint to sketch register index mapping, top level with configuration registers.
// Depends on fbd_pkg, fbd_mod_pipe, fbd_exp_pipe and assert_macros.svh.
//
// Usage:
//   Input channel: fingerprint with fingerprint_valid / fingerprint_stall.
//   Output channel: bucket_value and range_status with bucket_valid / bucket_stall.
//   Configuration: cfg_index and cfg_data, written when cfg_valid and cfg_ready are
//   both high; cfg_ready is always high. Write only while no item is in flight.
//   A result passes the 64-stage remainder pipeline (one fingerprint bit per
//   stage) and then the output register before bucket_valid. The exponential
//   path is 41 stages, 32 of them log2 squarings, and is padded to the same depth.
//   One item is accepted every cycle while the pipeline is not frozen.
//   When bucket_stall holds a waiting item, the whole pipeline freezes and
//   fingerprint_stall is raised; no item is lost or repeated.
//   Reset clears all valid bits and loads the register reset values.
`include "assert_macros.svh"

module fingerprint_to_bucket_distribution (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            fingerprint_valid,
  output logic                            fingerprint_stall,
  input  logic [fbd_pkg::FP_W-1:0]        fingerprint,
  output logic                            bucket_valid,
  input  logic                            bucket_stall,
  output logic [fbd_pkg::VAL_W-1:0]       bucket_value,
  output logic [1:0]                      range_status,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [fbd_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [fbd_pkg::RATE_W-1:0]      cfg_data
);

  logic [1:0]                  mode;
  logic [fbd_pkg::IDX_W-1:0]   min_index;
  logic [fbd_pkg::IDX_W-1:0]   max_index;
  logic [fbd_pkg::RATE_W-1:0]  exp_of_rate;
  logic [fbd_pkg::RATE_W-1:0]  inverse_rate;

  logic [fbd_pkg::SIZE_W-1:0]  size;
  fbd_pkg::exp_cfg_t           exp_cfg;
  logic                        adv;
  logic                        accept;
  logic [fbd_pkg::MOD_LAT-1:0] vld;
  logic [fbd_pkg::TZ_W-1:0]    tz_in;
  logic [fbd_pkg::TZ_W-1:0]    tz_d [0:fbd_pkg::MOD_LAT-1];
  fbd_pkg::exp_res_t           exp_res;
  fbd_pkg::exp_res_t           exp_d [0:fbd_pkg::EXP_PAD-1];
  logic [fbd_pkg::SIZE_W-1:0]  remainder;
  logic [fbd_pkg::VAL_W-1:0]   geo_sum;
  logic [fbd_pkg::VAL_W-1:0]   val;
  logic                        neg;
  logic [1:0]                  status;
  logic                        out_above;
  logic                        out_in_range;
  logic                        val_above;
  logic                        val_within;

  function automatic logic [fbd_pkg::TZ_W-1:0] trailing_zeros(
    input logic [fbd_pkg::FP_W-1:0] v
  );
    logic [fbd_pkg::FP_W-1:0] w;
    logic [fbd_pkg::TZ_W-1:0] n;
    w = v;
    n = '0;
    if (v == '0) begin
      n = fbd_pkg::TZ_W'(fbd_pkg::FP_W);
    end else begin
      if (w[31:0] == '0) begin n = n + 7'd32; w = w >> 32; end
      if (w[15:0] == '0) begin n = n + 7'd16; w = w >> 16; end
      if (w[7:0] == '0) begin n = n + 7'd8; w = w >> 8; end
      if (w[3:0] == '0) begin n = n + 7'd4; w = w >> 4; end
      if (w[1:0] == '0) begin n = n + 7'd2; w = w >> 2; end
      if (w[0] == 1'b0) begin n = n + 7'd1; end
    end
    return n;
  endfunction

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      mode         <= fbd_pkg::MODE_RESET;
      min_index    <= fbd_pkg::MIN_RESET;
      max_index    <= fbd_pkg::MAX_RESET;
      exp_of_rate  <= fbd_pkg::EXP_RATE_RESET;
      inverse_rate <= fbd_pkg::INV_RATE_RESET;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        fbd_pkg::CFG_MODE:         mode         <= cfg_data[1:0];
        fbd_pkg::CFG_MIN_INDEX:    min_index    <= cfg_data[fbd_pkg::IDX_W-1:0];
        fbd_pkg::CFG_MAX_INDEX:    max_index    <= cfg_data[fbd_pkg::IDX_W-1:0];
        fbd_pkg::CFG_EXP_OF_RATE:  exp_of_rate  <= cfg_data;
        fbd_pkg::CFG_INVERSE_RATE: inverse_rate <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  // An empty range gives a size of zero.
  assign size = (max_index >= min_index) ?
                ({1'b0, max_index} - {1'b0, min_index} + 33'd1) : '0;

  always_comb begin
    exp_cfg.exp_rate      = (exp_of_rate < fbd_pkg::ONE_Q32) ? fbd_pkg::ONE_Q32 : exp_of_rate;
    exp_cfg.exp_minus_one = exp_cfg.exp_rate - fbd_pkg::ONE_Q32;
    exp_cfg.inv_rate      = inverse_rate;
    exp_cfg.size          = size;
  end

  // The pipeline moves as a whole unless a finished item waits at the output.
  assign adv               = !bucket_valid || !bucket_stall;
  assign fingerprint_stall = !adv;
  assign accept            = fingerprint_valid && adv;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (adv) begin
      vld <= {vld[fbd_pkg::MOD_LAT-2:0], accept};
    end
  end

  fbd_mod_pipe u_mod (
    .clk         (clk),
    .en          (adv),
    .fingerprint (fingerprint),
    .size        (size),
    .remainder   (remainder)
  );

  fbd_exp_pipe u_exp (
    .clk         (clk),
    .en          (adv),
    .fingerprint (fingerprint),
    .cfg         (exp_cfg),
    .res         (exp_res)
  );

  assign tz_in = trailing_zeros(fingerprint);

  always_ff @(posedge clk) begin
    if (adv) begin
      tz_d[0] <= tz_in;
      for (int i = 1; i < fbd_pkg::MOD_LAT; i++) begin
        tz_d[i] <= tz_d[i-1];
      end
      exp_d[0] <= exp_res;
      for (int i = 1; i < fbd_pkg::EXP_PAD; i++) begin
        exp_d[i] <= exp_d[i-1];
      end
    end
  end

  assign geo_sum = {1'b0, min_index} + fbd_pkg::VAL_W'(tz_d[fbd_pkg::MOD_LAT-1]);

  always_comb begin
    neg = 1'b0;
    if (mode == fbd_pkg::MODE_GEOMETRIC) begin
      val = (geo_sum < {1'b0, max_index}) ? geo_sum : {1'b0, max_index};
    end else if (mode == fbd_pkg::MODE_EXPONENTIAL) begin
      val = exp_d[fbd_pkg::EXP_PAD-1].val;
      neg = exp_d[fbd_pkg::EXP_PAD-1].neg;
    end else if (size != '0) begin
      val = remainder + {1'b0, min_index};
    end else begin
      val = {1'b0, min_index};
    end

    // Below is reported before above.
    if (neg || (val < {1'b0, min_index})) begin
      status = fbd_pkg::STATUS_BELOW;
    end else if (val > {1'b0, max_index}) begin
      status = fbd_pkg::STATUS_ABOVE;
    end else begin
      status = fbd_pkg::STATUS_IN_RANGE;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      bucket_valid <= 1'b0;
    end else if (adv) begin
      bucket_valid <= vld[fbd_pkg::MOD_LAT-1];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      bucket_value <= neg ? '0 : val;
      range_status <= status;
    end
  end

  assign out_above    = bucket_valid && (range_status == fbd_pkg::STATUS_ABOVE);
  assign out_in_range = bucket_valid && (range_status == fbd_pkg::STATUS_IN_RANGE);
  assign val_above    = bucket_value > {1'b0, max_index};
  assign val_within   = (bucket_value >= {1'b0, min_index}) &&
                        (bucket_value <= {1'b0, max_index});

  `ASSERT_IMPL(a_above_is_above, out_above, val_above, "above status, value not above range")
  `ASSERT_IMPL(a_in_range_is_in, out_in_range, val_within, "in-range status, value outside")
  `ASSERT_NEXT(a_frozen_hold, !adv, vld == $past(vld), "pipeline valid bits moved while frozen")

endmodule

>>> rtl/core/fbd_mod_pipe.sv
// Pipelined restoring remainder: fingerprint modulo size, one bit per stage.
// Depends on fbd_pkg.
module fbd_mod_pipe (
  input  logic                          clk,
  input  logic                          en,
  input  logic [fbd_pkg::FP_W-1:0]      fingerprint,
  input  logic [fbd_pkg::SIZE_W-1:0]    size,
  output logic [fbd_pkg::SIZE_W-1:0]    remainder
);

  logic [fbd_pkg::SIZE_W-1:0] rem_st [0:fbd_pkg::MOD_LAT-1];
  logic [fbd_pkg::FP_W-1:0]   num_st [0:fbd_pkg::MOD_LAT-1];

  for (genvar i = 0; i < fbd_pkg::MOD_LAT; i++) begin : g_stage
    logic [fbd_pkg::SIZE_W-1:0] rem_cur;
    logic [fbd_pkg::FP_W-1:0]   num_cur;
    logic [fbd_pkg::SIZE_W:0]   trial;
    logic [fbd_pkg::SIZE_W:0]   diff;

    if (i == 0) begin : g_first
      assign rem_cur = '0;
      assign num_cur = fingerprint;
    end else begin : g_rest
      assign rem_cur = rem_st[i-1];
      assign num_cur = num_st[i-1];
    end

    always_comb begin
      trial = {rem_cur, num_cur[fbd_pkg::FP_W-1]};
      if (trial >= {1'b0, size}) begin
        diff = trial - {1'b0, size};
      end else begin
        diff = trial;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem_st[i] <= diff[fbd_pkg::SIZE_W-1:0];
        num_st[i] <= {num_cur[fbd_pkg::FP_W-2:0], 1'b0};
      end
    end
  end

  assign remainder = rem_st[fbd_pkg::MOD_LAT-1];

endmodule

>>> rtl/core/fbd_log2_pipe.sv
// Fractional part of log2 by repeated squaring, one squaring per stage.
// Depends on fbd_pkg.
module fbd_log2_pipe (
  input  logic                        clk,
  input  logic                        en,
  input  logic [32:0]                 y_in,
  input  logic [fbd_pkg::K_W-1:0]     k_in,
  output logic [fbd_pkg::FRAC_W-1:0]  frac_out,
  output logic [fbd_pkg::K_W-1:0]     k_out
);

  localparam int N = fbd_pkg::LOG_ITERATIONS;

  logic [32:0]                y_st    [0:N-1];
  logic [fbd_pkg::FRAC_W-1:0] frac_st [0:N-1];
  logic [fbd_pkg::K_W-1:0]    k_st    [0:N-1];

  for (genvar i = 0; i < N; i++) begin : g_iter
    logic [32:0]                y_cur;
    logic [fbd_pkg::FRAC_W-1:0] f_cur;
    logic [fbd_pkg::K_W-1:0]    k_cur;
    logic [65:0]                sq;
    logic [33:0]                ysq;
    logic [fbd_pkg::FRAC_W-1:0] f_next;

    if (i == 0) begin : g_first
      assign y_cur = y_in;
      assign f_cur = '0;
      assign k_cur = k_in;
    end else begin : g_rest
      assign y_cur = y_st[i-1];
      assign f_cur = frac_st[i-1];
      assign k_cur = k_st[i-1];
    end

    // y stays in [1,2) as Q.32; a square of 2.0 or more yields the next bit.
    always_comb begin
      sq     = {33'b0, y_cur} * {33'b0, y_cur};
      ysq    = sq[65:32];
      f_next = f_cur;
      f_next[fbd_pkg::FRAC_W-1-i] = ysq[33];
    end

    always_ff @(posedge clk) begin
      if (en) begin
        y_st[i]    <= ysq[33] ? ysq[33:1] : ysq[32:0];
        frac_st[i] <= f_next;
        k_st[i]    <= k_cur;
      end
    end
  end

  assign frac_out = frac_st[N-1];
  assign k_out    = k_st[N-1];

endmodule

>>> rtl/core/fbd_exp_pipe.sv
// Exponential mapping pipeline: scaled fingerprint, natural log, rate and size scaling.
// Depends on fbd_pkg and fbd_log2_pipe.
module fbd_exp_pipe (
  input  logic                       clk,
  input  logic                       en,
  input  logic [fbd_pkg::FP_W-1:0]   fingerprint,
  input  fbd_pkg::exp_cfg_t          cfg,
  output fbd_pkg::exp_res_t          res
);

  // Partial products of fingerprint times (e^r - 1).
  logic [63:0] pp00;
  logic [47:0] pp01;
  logic [63:0] pp10;
  logic [47:0] pp11;
  logic [64:0] low_sum;
  logic [64:0] mid_sum;
  logic [47:0] hi_part;
  logic [65:0] carry_sum;
  logic [47:0] t_scaled;
  logic [47:0] a_val;
  logic [fbd_pkg::K_W-1:0] k_val;
  logic [fbd_pkg::K_W-1:0] k_reg;
  logic [32:0] y_reg;
  logic [fbd_pkg::FRAC_W-1:0] frac;
  logic [fbd_pkg::K_W-1:0]    k_log;
  logic [fbd_pkg::L_W-1:0]    log2_val;
  logic [67:0] ln_prod;
  logic [fbd_pkg::L_W-1:0] ln_val;
  logic [67:0] q_lo;
  logic [51:0] q_hi;
  logic [52:0] q_val;
  logic [32:0] x_val;
  logic        neg_m3;
  logic [65:0] size_prod;

  always_ff @(posedge clk) begin
    if (en) begin
      pp00 <= {32'b0, fingerprint[31:0]}  * {32'b0, cfg.exp_minus_one[31:0]};
      pp01 <= {16'b0, fingerprint[31:0]}  * {32'b0, cfg.exp_minus_one[47:32]};
      pp10 <= {32'b0, fingerprint[63:32]} * {32'b0, cfg.exp_minus_one[31:0]};
      pp11 <= {16'b0, fingerprint[63:32]} * {32'b0, cfg.exp_minus_one[47:32]};
    end
  end

  // Adding (e^r - 1) once more gives the product with fingerprint plus one.
  always_ff @(posedge clk) begin
    if (en) begin
      low_sum <= {1'b0, pp00} + {17'b0, cfg.exp_minus_one};
      mid_sum <= {17'b0, pp01} + {1'b0, pp10};
      hi_part <= pp11;
    end
  end

  assign carry_sum = {33'b0, low_sum[64:32]} + {1'b0, mid_sum};

  always_ff @(posedge clk) begin
    if (en) begin
      t_scaled <= hi_part + {14'b0, carry_sum[65:32]};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      a_val <= cfg.exp_rate - t_scaled;
    end
  end

  // Integer part of log2 above one: highest set bit from bit 33 upwards.
  always_comb begin
    k_val = '0;
    for (int j = 0; j < 15; j++) begin
      if (a_val[33+j]) begin
        k_val = fbd_pkg::K_W'(j + 1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      k_reg <= k_val;
      y_reg <= 33'(a_val >> k_val);
    end
  end

  fbd_log2_pipe u_log2 (
    .clk      (clk),
    .en       (en),
    .y_in     (y_reg),
    .k_in     (k_reg),
    .frac_out (frac),
    .k_out    (k_log)
  );

  assign log2_val = {k_log, frac[fbd_pkg::FRAC_W-1:fbd_pkg::FRAC_W-32]};
  assign ln_prod  = {32'b0, log2_val} * {36'b0, fbd_pkg::LN2_Q32};

  always_ff @(posedge clk) begin
    if (en) begin
      ln_val <= ln_prod[67:32];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      q_lo <= {32'b0, ln_val} * {36'b0, cfg.inv_rate[31:0]};
      q_hi <= {16'b0, ln_val} * {36'b0, cfg.inv_rate[47:32]};
    end
  end

  assign q_val = {1'b0, q_hi} + {17'b0, q_lo[67:32]};

  // A quotient above one would give a negative index.
  always_ff @(posedge clk) begin
    if (en) begin
      neg_m3 <= (q_val > 53'(fbd_pkg::ONE_Q32)) && (cfg.size != '0);
      x_val  <= 33'(fbd_pkg::ONE_Q32) - q_val[32:0];
    end
  end

  assign size_prod = {33'b0, x_val} * {33'b0, cfg.size};

  always_ff @(posedge clk) begin
    if (en) begin
      res.val <= size_prod[64:32];
      res.neg <= neg_m3;
    end
  end

endmodule
